// ----- rtl/qe_pkg.sv -----
// Package for the quaternion to ZYX Euler angle converter.
// Holds widths, fixed-point constants, the arctangent table and the angle rounding.
// No dependencies.
package qe_pkg;

    localparam int unsigned DEF_CORDIC_STAGES = 16;

    // Rotation matrix terms in Q.28 fit in 35 signed bits.
    localparam int unsigned MW = 35;
    // CORDIC datapath width, leaving room for the gain and the pre-rotation.
    localparam int unsigned CW = 38;
    // Angle accumulator, Q2.30 with headroom for the quarter-turn pre-rotation.
    localparam int unsigned ZW = 34;
    // Output angle width, Q3.13.
    localparam int unsigned AW = 16;
    localparam int unsigned THR_W = 15;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic signed [AW-1:0] ANGLE_MAX = 16'sd25736;

    // atan(2^-i) in Q2.30, truncated up to i = 26 and rounded for i = 27 to 29; zero beyond.
    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h3243F6A8;
                1: v = 32'h1DAC6705;
                2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;
                4: v = 32'h03FEAB76;
                5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;
                7: v = 32'h007FFF55;
                8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                23: v = 32'h0000007F;
                24: v = 32'h0000003F;
                25: v = 32'h0000001F;
                26: v = 32'h0000000F;
                27: v = 32'h00000008;
                28: v = 32'h00000004;
                29: v = 32'h00000002;
                default: v = 32'h00000000;
            endcase
            return $signed({2'b00, v});
        end
    endfunction

    // Q2.30 angle to Q3.13: round half up, then saturate.
    function automatic logic signed [AW-1:0] to_q13(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] t;
        logic signed [ZW:0] a;
        begin
            t = {z[ZW-1], z} + (ZW+1)'(65536);
            a = t >>> 17;
            if (a > (ZW+1)'(ANGLE_MAX))
                return ANGLE_MAX;
            else if (a < -(ZW+1)'(ANGLE_MAX))
                return -ANGLE_MAX;
            else
                return a[AW-1:0];
        end
    endfunction

endpackage

// ----- rtl/qe_cordic.sv -----
// Pipelined vectoring CORDIC: one pre-rotation stage and one stage per iteration.
// Depends on qe_pkg for the arctangent table and the widths.
module qe_cordic
    import qe_pkg::*;
#(
    parameter int unsigned STAGES = DEF_CORDIC_STAGES,
    parameter int unsigned W = CW
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output logic signed [W-1:0]  x_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [W-1:0]  x_reg [0:STAGES];
    logic signed [W-1:0]  y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];

    // Vectors in the left half-plane are turned by a quarter turn first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign x_out = x_reg[STAGES];
    assign z_out = z_reg[STAGES];

endmodule

// ----- rtl/quaternion_to_euler_zyx_unit.sv -----
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qe_pkg and qe_cordic.
//
// This block turns a Q2.14 quaternion into yaw, pitch and roll in Q3.13 radians
// and flags gimbal lock. It is fully pipelined: it accepts one item every clock
// cycle while the output register can take a result, and its two CORDIC chains
// run in series (the magnitude chain's result feeds the pitch chain). The first
// two stages form the rotation matrix terms, three CORDICs then run side by
// side (roll with the magnitude, yaw, and the locked-branch roll), a split
// multiplier scales the magnitude, and a last CORDIC forms pitch. When the
// output register is full and not taken the whole pipeline holds, so no item
// is lost or repeated. The lock threshold is written through the register port
// at address 0 and should only change while idle.
module quaternion_to_euler_zyx_unit
    import qe_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z (lowest first)
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // yaw_angle, pitch_angle, roll_angle (lowest first)
    output logic        m_axis_tuser,   // gimbal_locked
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LAT = CORDIC_STAGES + 1;

    typedef struct packed {
        logic signed [MW-1:0] m20;
        logic                 zero_roll;
        logic                 zero_yaw;
        logic                 zero_lroll;
    } side1_t;

    typedef struct packed {
        logic signed [AW-1:0] yaw;
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] lroll;
        logic                 m20_pos;
        logic                 zero_pitch;
        logic                 locked;
    } side2_t;

    // Register port.
    logic [THR_W-1:0] thr_reg;

    assign pready = 1'b1;
    assign prdata = {{(32-THR_W){1'b0}}, thr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (psel && penable && pwrite && paddr == 3'd0)
            thr_reg <= pwdata[THR_W-1:0];
    end

    // The whole pipeline moves when the output register can take a result.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: the nine products.
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg, xz_reg, wy_reg;
    logic signed [31:0] yz_reg, wx_reg;
    logic v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
        end
    end

    // Stage 2: matrix terms in Q.28.
    logic signed [MW-1:0] m00_reg, m10_reg, m11_reg, m20_reg, m21_reg, m22_reg, nm01_reg;
    logic v2_reg;

    function automatic logic signed [MW-1:0] ext(input logic signed [31:0] a);
        return MW'(a);
    endfunction

    localparam logic signed [MW-1:0] ONE_Q28 = MW'(268435456);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg  <= ONE_Q28 - ((ext(yy_reg) + ext(zz_reg)) <<< 1);
            m11_reg  <= ONE_Q28 - ((ext(xx_reg) + ext(zz_reg)) <<< 1);
            m22_reg  <= ONE_Q28 - ((ext(xx_reg) + ext(yy_reg)) <<< 1);
            m10_reg  <= (ext(xy_reg) + ext(wz_reg)) <<< 1;
            nm01_reg <= (ext(wz_reg) - ext(xy_reg)) <<< 1;
            m20_reg  <= (ext(xz_reg) - ext(wy_reg)) <<< 1;
            m21_reg  <= (ext(yz_reg) + ext(wx_reg)) <<< 1;
        end
    end

    // First CORDIC group: magnitude and roll, yaw, locked-branch roll.
    logic signed [CW-1:0] mag_raw;
    logic signed [ZW-1:0] z_roll, z_yaw, z_lroll;

    qe_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_cordic_roll (
        .clk   (clk),
        .en    (en),
        .x_in  (CW'(m22_reg)),
        .y_in  (CW'(m21_reg)),
        .x_out (mag_raw),
        .z_out (z_roll)
    );

    logic signed [CW-1:0] unused_yaw_x;
    logic signed [CW-1:0] unused_lroll_x;

    qe_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_cordic_yaw (
        .clk   (clk),
        .en    (en),
        .x_in  (CW'(m00_reg)),
        .y_in  (CW'(m10_reg)),
        .x_out (unused_yaw_x),
        .z_out (z_yaw)
    );

    qe_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_cordic_lroll (
        .clk   (clk),
        .en    (en),
        .x_in  (CW'(m11_reg)),
        .y_in  (CW'(nm01_reg)),
        .x_out (unused_lroll_x),
        .z_out (z_lroll)
    );

    side1_t side1_reg [0:LAT-1];
    logic   vd1_reg   [0:LAT-1];
    side1_t side1_in;

    assign side1_in.m20        = m20_reg;
    assign side1_in.zero_roll  = (m22_reg == '0) && (m21_reg == '0);
    assign side1_in.zero_yaw   = (m00_reg == '0) && (m10_reg == '0);
    assign side1_in.zero_lroll = (m11_reg == '0) && (nm01_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= side1_in;
            for (int k = 1; k < LAT; k++)
                side1_reg[k] <= side1_reg[k-1];
        end
    end

    // Stage 3: partial products of the gain correction, angles rounded.
    logic [42:0]          plo_reg;
    logic signed [43:0]   phi_reg;
    logic signed [AW-1:0] yaw3_reg, roll3_reg, lroll3_reg;
    logic signed [MW-1:0] m20_3_reg;
    logic v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg    <= 43'(mag_raw[18:0]) * 43'(INV_GAIN_Q24);
            phi_reg    <= $signed(mag_raw[CW-1:19]) * $signed({1'b0, INV_GAIN_Q24});
            yaw3_reg   <= side1_reg[LAT-1].zero_yaw ? '0 : to_q13(z_yaw);
            roll3_reg  <= side1_reg[LAT-1].zero_roll ? '0 : to_q13(z_roll);
            lroll3_reg <= side1_reg[LAT-1].zero_lroll ? '0 : to_q13(z_lroll);
            m20_3_reg  <= side1_reg[LAT-1].m20;
        end
    end

    // Stage 4: c = raw / K, rounded half up, in Q.28.
    logic signed [63:0]   csum;
    logic signed [63:0]   cshift;
    logic signed [CW-1:0] c_reg;
    logic signed [AW-1:0] yaw4_reg, roll4_reg, lroll4_reg;
    logic signed [MW-1:0] m20_4_reg;
    logic v4_reg;

    assign csum = (64'(phi_reg) <<< 19) + $signed(64'(plo_reg)) + 64'sd8388608;
    assign cshift = csum >>> 24;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= cshift[CW-1:0];
            yaw4_reg   <= yaw3_reg;
            roll4_reg  <= roll3_reg;
            lroll4_reg <= lroll3_reg;
            m20_4_reg  <= m20_3_reg;
        end
    end

    // Second CORDIC: pitch from (c, -m20); lock decided alongside.
    logic signed [CW-1:0] unused_pitch_x;
    logic signed [ZW-1:0] z_pitch;
    logic signed [CW-1:0] nm20;

    assign nm20 = -CW'(m20_4_reg);

    qe_cordic #(.STAGES(CORDIC_STAGES), .W(CW)) u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .x_in  (c_reg),
        .y_in  (nm20),
        .x_out (unused_pitch_x),
        .z_out (z_pitch)
    );

    side2_t side2_reg [0:LAT-1];
    logic   vd2_reg   [0:LAT-1];
    side2_t side2_in;

    assign side2_in.yaw        = yaw4_reg;
    assign side2_in.roll       = roll4_reg;
    assign side2_in.lroll      = lroll4_reg;
    assign side2_in.m20_pos    = m20_4_reg > 0;
    assign side2_in.zero_pitch = (c_reg == '0) && (m20_4_reg == '0);
    assign side2_in.locked     = c_reg <= $signed(CW'({thr_reg, 14'b0}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg[0] <= side2_in;
            for (int k = 1; k < LAT; k++)
                side2_reg[k] <= side2_reg[k-1];
        end
    end

    // Output register.
    side2_t               fin;
    logic signed [AW-1:0] pitch_q, yaw_sel, roll_sel;

    assign fin     = side2_reg[LAT-1];
    assign pitch_q = fin.zero_pitch ? '0 : to_q13(z_pitch);

    always_comb
    begin
        if (fin.locked)
        begin
            yaw_sel  = '0;
            roll_sel = fin.m20_pos ? fin.lroll : -fin.lroll;
        end
        else
        begin
            yaw_sel  = fin.yaw;
            roll_sel = fin.roll;
        end
    end

    logic [47:0] out_data_reg;
    logic        out_lock_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {roll_sel, pitch_q, yaw_sel};
            out_lock_reg <= fin.locked;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_lock_reg;

    // Valid bits that travel with the items.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LAT; k++)
            begin
                vd1_reg[k] <= 1'b0;
                vd2_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg     <= s_axis_tvalid;
            v2_reg     <= v1_reg;
            vd1_reg[0] <= v2_reg;
            for (int k = 1; k < LAT; k++)
                vd1_reg[k] <= vd1_reg[k-1];
            v3_reg     <= vd1_reg[LAT-1];
            v4_reg     <= v3_reg;
            vd2_reg[0] <= v4_reg;
            for (int k = 1; k < LAT; k++)
                vd2_reg[k] <= vd2_reg[k-1];
            out_valid_reg <= vd2_reg[LAT-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule
